// ----- hdl/modexp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation core.
// ----------------------------------------------------------------------------
package modexp_pkg;

    // Configuration register indexes
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LAUNCH = 4'b0010,
        S_WAIT   = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    // Product kind currently running through the cell row
    typedef enum logic [2:0] {
        OP_REDUCE = 3'b001,
        OP_SQUARE = 3'b010,
        OP_MULT   = 3'b100
    } op_t;

endpackage

// ----- hdl/modexp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_cell
// One step of the interleaved modular product: r = 2r (+ a) mod m.
// ----------------------------------------------------------------------------
module modexp_cell #(
    parameter int W       = 16,
    parameter int BIT_POS = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid_in,
    input  logic [W-1:0] r_in,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         valid_out,
    output logic [W-1:0] r_out
);
    logic [W:0]   dbl;
    logic [W:0]   sum;
    logic [W-1:0] r_dbl;
    logic [W-1:0] r_add;
    logic [W-1:0] r_next;
    logic         valid_reg;
    logic [W-1:0] r_reg;

    // Double and reduce, then add the multiplicand when this bit is set
    always_comb
    begin
        dbl    = {r_in, 1'b0};
        r_dbl  = (dbl >= {1'b0, m}) ? W'(dbl - {1'b0, m}) : dbl[W-1:0];
        sum    = {1'b0, r_dbl} + {1'b0, a};
        r_add  = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
        r_next = b[BIT_POS] ? r_add : r_dbl;
    end

    // Hand the partial product to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign valid_out = valid_reg;
    assign r_out     = r_reg;

endmodule

// ----- hdl/modular_exponentiation_core.sv -----
`timescale 1ns / 1ps
// Work per beat: one modular reduction plus up to 2*MOD_WIDTH modular products,
// each passing through the row of MOD_WIDTH cells. One beat is in work at a
// time; a new beat is taken only once the last result is in the output register.
// Reset: asynchronous active low; modulus resets to 2, exponent to 1.
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Square-and-multiply modular exponentiation over a systolic cell row.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int MOD_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: message [MOD_WIDTH-1:0], zero padded to bytes
    input  logic [((MOD_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: result [MOD_WIDTH-1:0], zero padded to bytes
    output logic [((MOD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    input  logic                                  cfg_we,
    input  logic                                  cfg_addr,
    input  logic [MOD_WIDTH-1:0]                  cfg_data
);
    import modexp_pkg::*;

    localparam int W      = MOD_WIDTH;
    localparam int TD_W   = ((MOD_WIDTH + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(MOD_WIDTH);

    logic [W-1:0]     modulus_reg;
    logic [W-1:0]     exponent_reg;
    state_t           state_reg;
    op_t              op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     base_reg;
    logic [W-1:0]     acc_reg;
    logic             out_valid_reg;
    logic [W-1:0]     out_data_reg;

    logic [W:0]       valid_vec;
    logic [W-1:0]     r_vec [W+1];
    logic             chain_done;
    logic [W-1:0]     prod;
    logic [W-1:0]     one_mod;

    assign one_mod = (modulus_reg == W'(1)) ? '0 : W'(1);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= W'(2);
            exponent_reg <= W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MODULUS:  modulus_reg  <= cfg_data;
                REG_EXPONENT: exponent_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Row of product cells; cell i handles multiplier bit W-1-i
    assign valid_vec[0] = (state_reg == S_LAUNCH);
    assign r_vec[0]     = '0;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        modexp_cell #(
            .W       (W),
            .BIT_POS (W - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_vec[i]),
            .r_in      (r_vec[i]),
            .a         (a_reg),
            .b         (b_reg),
            .m         (modulus_reg),
            .valid_out (valid_vec[i+1]),
            .r_out     (r_vec[i+1])
        );
    end

    assign chain_done = valid_vec[W];
    assign prod       = r_vec[W];

    // Exponent sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_REDUCE;
            idx_reg       <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            base_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // Load a finished result, or drop the output beat once taken
            if ((state_reg == S_DONE) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (modulus_reg == '0)
                        begin
                            acc_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            acc_reg   <= one_mod;
                            op_reg    <= OP_REDUCE;
                            a_reg     <= one_mod;
                            b_reg     <= s_axis_tdata[W-1:0];
                            state_reg <= S_LAUNCH;
                        end
                    end
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (chain_done)
                    begin
                        unique case (op_reg)
                            OP_REDUCE:
                            begin
                                base_reg  <= prod;
                                op_reg    <= OP_SQUARE;
                                a_reg     <= acc_reg;
                                b_reg     <= acc_reg;
                                idx_reg   <= IDX_W'(W - 1);
                                state_reg <= S_LAUNCH;
                            end
                            OP_SQUARE:
                            begin
                                acc_reg <= prod;
                                if (exponent_reg[idx_reg])
                                begin
                                    op_reg    <= OP_MULT;
                                    a_reg     <= prod;
                                    b_reg     <= base_reg;
                                    state_reg <= S_LAUNCH;
                                end
                                else if (idx_reg == '0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    idx_reg   <= idx_reg - 1'b1;
                                    a_reg     <= prod;
                                    b_reg     <= prod;
                                    state_reg <= S_LAUNCH;
                                end
                            end
                            OP_MULT:
                            begin
                                acc_reg <= prod;
                                if (idx_reg == '0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    idx_reg   <= idx_reg - 1'b1;
                                    op_reg    <= OP_SQUARE;
                                    a_reg     <= prod;
                                    b_reg     <= prod;
                                    state_reg <= S_LAUNCH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg  <= acc_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TD_W'(out_data_reg);

`ifndef SYNTHESIS
    // Only one partial product travels the row at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_vec))
        else $error("more than one product in the cell row");

    // Row is empty whenever a new beat can be taken
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (valid_vec == '0))
        else $error("cell row busy while idle");

    // A product leaves the row only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        chain_done |-> (state_reg == S_WAIT))
        else $error("product finished outside wait state");

    // Launch is always followed by wait
    a_launch_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAUNCH) |=> (state_reg == S_WAIT))
        else $error("launch not followed by wait");
`endif

endmodule

// ----- tb/modexp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_checker
// Watches both stream channels and the register port of the exponentiation
// core, computes each expected power by square-and-multiply and compares the
// result beats in order.
// ----------------------------------------------------------------------------
module modexp_checker #(
    parameter int MOD_WIDTH = 16,
    parameter int DW        = ((MOD_WIDTH+7)/8)*8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [DW-1:0]        s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [DW-1:0]        m_axis_tdata,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [MOD_WIDTH-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending_count,
    output int                   result_count
);
    import modexp_pkg::*;

    logic [MOD_WIDTH-1:0] cur_modulus;
    logic [MOD_WIDTH-1:0] cur_exponent;
    logic [MOD_WIDTH-1:0] expected_powers[$];

    // (a + b) mod m with the carry kept
    function automatic logic [MOD_WIDTH-1:0] sum_mod(
        input logic [MOD_WIDTH-1:0] a, input logic [MOD_WIDTH-1:0] b,
        input logic [MOD_WIDTH-1:0] m);
        logic [MOD_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[MOD_WIDTH-1:0];
    endfunction

    function automatic logic [MOD_WIDTH-1:0] product_mod(
        input logic [MOD_WIDTH-1:0] a, input logic [MOD_WIDTH-1:0] b,
        input logic [MOD_WIDTH-1:0] m);
        logic [MOD_WIDTH-1:0] r;
        r = '0;
        for (int i = MOD_WIDTH - 1; i >= 0; i--)
        begin
            r = sum_mod(r, r, m);
            if (b[i])
                r = sum_mod(r, a, m);
        end
        return r;
    endfunction

    function automatic logic [MOD_WIDTH-1:0] power_mod(
        input logic [MOD_WIDTH-1:0] msg, input logic [MOD_WIDTH-1:0] e,
        input logic [MOD_WIDTH-1:0] m);
        logic [MOD_WIDTH-1:0] r;
        logic [MOD_WIDTH-1:0] base;
        if (m == 0)
            return '0;
        base = msg % m;
        r = (m == 1) ? '0 : 1;
        for (int i = MOD_WIDTH - 1; i >= 0; i--)
        begin
            r = product_mod(r, r, m);
            if (e[i])
                r = product_mod(r, base, m);
        end
        return r;
    endfunction

    assign pending_count = expected_powers.size();

    // Track registers, predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_modulus  <= 2;
            cur_exponent <= 1;
            fail_count   <= 0;
            result_count <= 0;
            expected_powers.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_MODULUS)
                    cur_modulus <= cfg_data;
                else if (cfg_addr == REG_EXPONENT)
                    cur_exponent <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_powers.push_back(power_mod(s_axis_tdata[MOD_WIDTH-1:0],
                                                    cur_exponent, cur_modulus));
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count <= result_count + 1;
                if (expected_powers.size() == 0)
                begin
                    $error("result beat %0h with nothing expected", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    logic [MOD_WIDTH-1:0] want;
                    want = expected_powers.pop_front();
                    if (m_axis_tdata != DW'(want))
                    begin
                        $error("result mismatch: expected %0h actual %0h", want,
                               m_axis_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the exponentiation core: directed corner messages and keys,
// then random messages over several key settings with varied idling and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import modexp_pkg::*;

    localparam int MW = 16;
    localparam int DW = ((MW+7)/8)*8;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 700;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [DW-1:0] m_axis_tdata;
    logic          cfg_we;
    logic          cfg_addr;
    logic [MW-1:0] cfg_data;
    int            fail_count;
    int            pending_count;
    int            result_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_output;
    int            cycle_count;
    int            sent_count;

    modular_exponentiation_core #(.MOD_WIDTH(MW)) u_dut (.*);

    modexp_checker #(.MOD_WIDTH(MW)) u_checker (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[modular_exponentiation_core] ERROR");
            $finish;
        end
    end

    // Drive output ready with random stalls, or hold off entirely
    always @(posedge clk)
    begin
        if (hold_output)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic idx, input logic [MW-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Stop offering beats and wait for the core to drain before touching the key
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_key(input logic [MW-1:0] n, input logic [MW-1:0] e);
        drain();
        write_reg(REG_MODULUS, n);
        write_reg(REG_EXPONENT, e);
    endtask

    // Offer one message beat, with random leading gaps; valid stays up afterwards
    task automatic send_message(input logic [MW-1:0] msg);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'(msg);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
    endtask

    function automatic logic [MW-1:0] rand_message(input int kind);
        case (kind)
            0: return '0;
            1: return '1;
            2: return 1;
            default: return MW'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        logic [MW-1:0] keys_n[8];
        logic [MW-1:0] keys_e[8];
        rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
        m_axis_tready = 0; cfg_we = 0; cfg_addr = REG_MODULUS; cfg_data = '0;
        send_idle_pct = 0; recv_idle_pct = 0; hold_output = 0;
        cycle_count = 0; sent_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Reset key: modulus 2, exponent 1
        send_message(0);
        send_message(16'hffff);
        send_message(3);
        // Classic small key, message above modulus, exponent zero
        load_key(3233, 17);
        send_message(65);
        send_message(16'hffff);
        send_message(3233);
        send_message(3234);
        load_key(3233, 0);
        send_message(0);
        send_message(1234);
        // Modulus one, then zero
        load_key(1, 16'hffff);
        send_message(7);
        send_message(16'hffff);
        load_key(0, 5);
        send_message(9);
        send_message(0);
        // Largest modulus and exponent
        load_key(16'hffff, 16'hffff);
        send_message(16'hfffe);
        send_message(16'hffff);
        send_message(16'h8000);
        send_message(2);
        load_key(16'hfffd, 16'h5555);
        send_message(16'haaaa);
        send_message(16'h5555);
        drain();

        // Long output hold-off so the core backs up
        fork
            begin
                hold_output = 1;
                repeat (3000) @(posedge clk);
                hold_output = 0;
            end
            begin
                for (int i = 0; i < 4; i++)
                    send_message(MW'($urandom_range(65535)));
                s_axis_tvalid <= 1'b0;
            end
        join

        keys_n = '{3233, 2, 16'hffff, 55, 16'h8001, 0, 0, 0};
        keys_e = '{2753, 16'hffff, 3, 0, 16'h8000, 0, 0, 0};
        for (int k = 5; k < 8; k++)
        begin
            keys_n[k] = MW'($urandom_range(65535, 2));
            keys_e[k] = MW'($urandom_range(65535));
        end

        // Random traffic under three idling regimes
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 10 : 0;
            for (int k = 0; k < 8; k++)
            begin
                load_key(keys_n[k], keys_e[k]);
                for (int i = 0; i < 45; i++)
                    send_message(rand_message($urandom_range(9)));
            end
        end

        drain();
        $display("Sent %0d messages over %0d keys and three idling regimes;", sent_count,
                 31);
        $display("checked %0d results, including a 3000-cycle output hold-off.",
                 result_count);
        if (fail_count == 0)
            $display("[modular_exponentiation_core] OK");
        else
            $display("[modular_exponentiation_core] ERROR");
        $finish;
    end
endmodule
